>>> design/ckx_pkg.sv
// ckx_pkg: constants shared by the canonical k-mer extractor
// character codes, register indexes, field widths and the window length cap
// no dependencies
package ckx_pkg;

   // widths of the stream fields and configuration registers
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned KmerWidth  = 64;
   localparam int unsigned KlenWidth  = 6;
   localparam int unsigned CountWidth = 6;

   // longest window the registers are built for
   localparam int unsigned MaxK   = 32;
   localparam int unsigned CapK   = (MaxK < 32) ? MaxK : 32;
   localparam logic [KlenWidth-1:0] KlenCap   = KlenWidth'(CapK);
   localparam logic [KlenWidth-1:0] KlenReset = 6'd31;

   localparam logic [CountWidth-1:0] CountMax = '1;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_KMER_LENGTH  = 1'b0,
      CSR_EMIT_INVALID = 1'b1
   } csr_index_type;

   // accepted characters
   localparam logic [CharWidth-1:0] ChUpperA = 8'h41;
   localparam logic [CharWidth-1:0] ChUpperC = 8'h43;
   localparam logic [CharWidth-1:0] ChUpperG = 8'h47;
   localparam logic [CharWidth-1:0] ChUpperT = 8'h54;
   localparam logic [CharWidth-1:0] ChLowerA = 8'h61;
   localparam logic [CharWidth-1:0] ChLowerC = 8'h63;
   localparam logic [CharWidth-1:0] ChLowerG = 8'h67;
   localparam logic [CharWidth-1:0] ChLowerT = 8'h74;

   typedef enum logic [1:0] {
      BASE_A = 2'd0,
      BASE_C = 2'd1,
      BASE_G = 2'd2,
      BASE_T = 2'd3
   } base_type;

   // complement of a 2-bit base code
   localparam logic [1:0] CompMask = 2'b11;

endpackage

>>> design/canonical_kmer_extractor_top.sv
// canonical_kmer_extractor_top: streams DNA characters, emits canonical k-mers
// forward and reverse-complement window registers, min select, result register
// depends on ckx_pkg
//
// an accepted character's k-mer appears on rsp_ in the cycle after it is accepted
// throughput: one character per cycle; the result register frees itself when
//    rsp_tready is high, so req_tready stays high under a streaming consumer
// reset (synchronous, active high): window registers and counters cleared,
//    kmer_length 31, emit_invalid_windows 0, no result pending
module canonical_kmer_extractor_top
   import ckx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CharWidth-1:0]  req_tdata,   // [7:0] base_char
   input  logic                  req_tuser,   // [0] read_start

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [KmerWidth-1:0]  rsp_tdata,   // [63:0] canonical_kmer
   output logic                  rsp_tuser,   // [0] window_valid

   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [KlenWidth-1:0]  csr_wdata
);

   logic [KlenWidth-1:0]  kmer_length_ff;
   logic                  emit_invalid_ff;

   logic [KmerWidth-1:0]  forward_ff, forward_in;
   logic [KmerWidth-1:0]  reverse_ff, reverse_in;
   logic [CountWidth-1:0] clean_run_ff, clean_run_in;
   logic [CountWidth-1:0] chars_seen_ff, chars_seen_in;

   logic                  out_valid_ff, out_valid_in;
   logic [KmerWidth-1:0]  out_kmer_ff, out_kmer_in;
   logic                  out_clean_ff, out_clean_in;

   logic                  accept;
   logic [KlenWidth-1:0]  eff_k;
   logic [KmerWidth-1:0]  mask;
   logic [1:0]            code;
   logic                  is_base;
   logic [KmerWidth-1:0]  fwd_base, rev_base;
   logic [KmerWidth-1:0]  rev_insert;
   logic [KmerWidth-1:0]  kmer_min;
   logic                  window_closed;
   logic                  window_clean;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff  <= KlenReset;
         emit_invalid_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KMER_LENGTH:  kmer_length_ff  <= csr_wdata;
            CSR_EMIT_INVALID: emit_invalid_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // window length: zero acts as one, capped at the register width
   always_comb begin
      eff_k = kmer_length_ff;
      if (eff_k == '0) begin
         eff_k = KlenWidth'(1);
      end
      if (eff_k > KlenCap) begin
         eff_k = KlenCap;
      end
   end

   always_comb begin
      for (int i = 0; i < KmerWidth; i++) begin
         mask[i] = (7'(i) < {eff_k, 1'b0});
      end
   end

   // character decode
   always_comb begin
      is_base = 1'b1;
      code    = BASE_A;
      case (req_tdata)
         ChUpperA, ChLowerA: code = BASE_A;
         ChUpperC, ChLowerC: code = BASE_C;
         ChUpperG, ChLowerG: code = BASE_G;
         ChUpperT, ChLowerT: code = BASE_T;
         default:            is_base = 1'b0;
      endcase
   end

   // a new read starts from cleared registers
   assign fwd_base = req_tuser ? '0 : forward_ff;
   assign rev_base = req_tuser ? '0 : reverse_ff;

   assign rev_insert = {62'b0, code ^ CompMask} << {eff_k - KlenWidth'(1), 1'b0};

   always_comb begin
      forward_in    = forward_ff;
      reverse_in    = reverse_ff;
      clean_run_in  = clean_run_ff;
      chars_seen_in = chars_seen_ff;
      if (accept) begin
         if (is_base) begin
            forward_in = {fwd_base[KmerWidth-3:0], code} & mask;
            reverse_in = ({2'b00, rev_base[KmerWidth-1:2]} | rev_insert) & mask;
         end else begin
            forward_in = fwd_base;
            reverse_in = rev_base;
         end
         if (!is_base) begin
            clean_run_in = '0;
         end else if (req_tuser) begin
            clean_run_in = CountWidth'(1);
         end else if (clean_run_ff != CountMax) begin
            clean_run_in = clean_run_ff + CountWidth'(1);
         end
         if (req_tuser) begin
            chars_seen_in = CountWidth'(1);
         end else if (chars_seen_ff != CountMax) begin
            chars_seen_in = chars_seen_ff + CountWidth'(1);
         end
      end
   end

   assign kmer_min      = (forward_in <= reverse_in) ? forward_in : reverse_in;
   assign window_closed = (chars_seen_in >= eff_k);
   assign window_clean  = (clean_run_in >= eff_k);

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kmer_in  = out_kmer_ff;
      out_clean_in = out_clean_ff;
      if (accept) begin
         out_valid_in = window_closed && (window_clean || emit_invalid_ff);
         out_kmer_in  = window_clean ? kmer_min : '0;
         out_clean_in = window_clean;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_ff    <= '0;
         reverse_ff    <= '0;
         clean_run_ff  <= '0;
         chars_seen_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         forward_ff    <= forward_in;
         reverse_ff    <= reverse_in;
         clean_run_ff  <= clean_run_in;
         chars_seen_ff <= chars_seen_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kmer_ff  <= out_kmer_in;
      out_clean_ff <= out_clean_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_kmer_ff;
   assign rsp_tuser  = out_clean_ff;

endmodule

>>> test/tb_canonical_kmer_extractor_top.sv
// tb_canonical_kmer_extractor_top: self-checking bench for the canonical k-mer extractor
// predicts each window from its own copy of the shift registers and run counters
// depends on ckx_pkg and canonical_kmer_extractor_top
`timescale 1ns / 1ps

module tb_canonical_kmer_extractor_top;
   import ckx_pkg::*;

   localparam int unsigned StallLimit = 1000;

   typedef struct packed {
      logic [KmerWidth-1:0] kmer;
      logic                 valid;
   } window_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CharWidth-1:0] req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [KmerWidth-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [0:0]           csr_index = CSR_KMER_LENGTH;
   logic [KlenWidth-1:0] csr_wdata = '0;

   // predictor state
   logic [KlenWidth-1:0]  klen_cfg = KlenReset;
   logic                  emit_cfg = 1'b0;
   logic [KmerWidth-1:0]  fwd_window = '0;
   logic [KmerWidth-1:0]  rc_window = '0;
   logic [CountWidth-1:0] clean_bases = '0;
   logic [CountWidth-1:0] read_chars = '0;

   window_result_type pending_windows[$];
   int unsigned       fail_count = 0;
   int unsigned       idle_cycles = 0;
   bit                idling_on = 1'b1;

   canonical_kmer_extractor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void predict_window(input logic [CharWidth-1:0] ch, input logic start);
      int unsigned          k;
      logic [KmerWidth-1:0] mask;
      base_type             code;
      logic                 is_base;
      window_result_type    res;
      k = klen_cfg;
      if (k < 1) k = 1;
      if (k > CapK) k = CapK;
      mask = (k >= 32) ? '1 : (64'd1 << (2 * k)) - 64'd1;
      is_base = 1'b1;
      case (ch)
         ChUpperA, ChLowerA: code = BASE_A;
         ChUpperC, ChLowerC: code = BASE_C;
         ChUpperG, ChLowerG: code = BASE_G;
         ChUpperT, ChLowerT: code = BASE_T;
         default: begin
            code = BASE_A;
            is_base = 1'b0;
         end
      endcase
      if (start) begin
         fwd_window = '0;
         rc_window = '0;
         clean_bases = '0;
         read_chars = '0;
      end
      if (is_base) begin
         fwd_window = ((fwd_window << 2) | KmerWidth'(code)) & mask;
         // complement enters at base position k-1
         rc_window = ((rc_window >> 2) | (KmerWidth'(code ^ CompMask) << (2 * (k - 1)))) & mask;
         if (clean_bases != CountMax) clean_bases++;
      end else begin
         clean_bases = '0;
      end
      if (read_chars != CountMax) read_chars++;
      if (read_chars >= k) begin
         if (clean_bases >= k) begin
            res.kmer = (fwd_window <= rc_window) ? fwd_window : rc_window;
            res.valid = 1'b1;
            pending_windows.push_back(res);
         end else if (emit_cfg) begin
            res.kmer = '0;
            res.valid = 1'b0;
            pending_windows.push_back(res);
         end
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      window_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_windows.size() == 0) begin
            $error("unexpected result: canonical_kmer %h window_valid %b", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            exp_res = pending_windows.pop_front();
            if (rsp_tdata !== exp_res.kmer) begin
               $error("canonical_kmer: expected %h actual %h", exp_res.kmer, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== exp_res.valid) begin
               $error("window_valid: expected %b actual %b", exp_res.valid, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // consumer back-pressure
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("FAIL canonical_kmer_extractor_top");
         $finish;
      end
   end

   task automatic send_char(input logic [CharWidth-1:0] ch, input logic start);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_window(ch, start);
   endtask

   // hold the sender until every expected window is out, then let the pipe settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_windows.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(input logic [KlenWidth-1:0] klen, input logic emit);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_KMER_LENGTH;
      csr_wdata <= klen;
      @(posedge clock);
      klen_cfg = klen;
      csr_index <= CSR_EMIT_INVALID;
      csr_wdata <= KlenWidth'(emit);
      @(posedge clock);
      emit_cfg = emit;
      csr_we <= 1'b0;
   endtask

   function automatic logic [CharWidth-1:0] random_base();
      case ($urandom_range(0, 7))
         0: return ChUpperA;
         1: return ChUpperC;
         2: return ChUpperG;
         3: return ChUpperT;
         4: return ChLowerA;
         5: return ChLowerC;
         6: return ChLowerG;
         default: return ChLowerT;
      endcase
   endfunction

   // mostly clean reads a bit longer than the window, with stray bytes and missing starts
   task automatic send_reads(input int unsigned item_goal);
      int unsigned sent;
      int unsigned read_size;
      int unsigned k;
      logic [CharWidth-1:0] ch;
      sent = 0;
      k = (klen_cfg == 0) ? 1 : ((klen_cfg > CapK) ? CapK : klen_cfg);
      while (sent < item_goal) begin
         if ($urandom_range(0, 7) == 0) read_size = $urandom_range(1, k);
         else read_size = k + $urandom_range(0, 24);
         for (int unsigned i = 0; i < read_size; i++) begin
            if ($urandom_range(0, 29) == 0) ch = CharWidth'($urandom_range(0, 255));
            else ch = random_base();
            send_char(ch, (i == 0) && ($urandom_range(0, 9) != 0));
            sent++;
         end
      end
   endtask

   task automatic test_reset_config();
      // k is 31 after reset, so a short read yields nothing
      send_char(ChUpperA, 1'b1);
      send_char(ChLowerG, 1'b0);
      send_char(8'h4E, 1'b0);
   endtask

   task automatic test_single_base_query();
      // zero length behaves as one base
      configure(6'd0, 1'b1);
      send_char(ChUpperA, 1'b1);
      send_char(ChLowerC, 1'b0);
      send_char(ChUpperG, 1'b0);
      send_char(ChLowerT, 1'b0);
      send_char(ChLowerA, 1'b0);
      send_char(ChUpperC, 1'b0);
      send_char(ChLowerG, 1'b0);
      send_char(ChUpperT, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h4E, 1'b0);
   endtask

   task automatic test_ingest_skip();
      configure(6'd2, 1'b0);
      send_char(ChUpperG, 1'b1);
      send_char(ChUpperC, 1'b0);
      send_char(8'h78, 1'b0);
      send_char(ChUpperA, 1'b0);
      send_char(ChUpperT, 1'b0);
      // new read mid-stream restarts the counters
      send_char(ChUpperT, 1'b1);
      send_char(ChLowerT, 1'b0);
   endtask

   task automatic test_length_change();
      // registers keep the previous read and get masked to the new length
      configure(6'd3, 1'b0);
      send_char(ChUpperA, 1'b0);
      send_char(ChLowerC, 1'b0);
   endtask

   task automatic test_random_phases();
      logic [KlenWidth-1:0] klens[8];
      logic                 emits[8];
      klens = '{6'd63, 6'd32, 6'd1, 6'd0, 6'd31, 6'd5, 6'd17, 6'd0};
      emits = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      klens[7] = KlenWidth'($urandom_range(0, 63));
      emits[7] = 1'(($urandom_range(0, 1)));
      foreach (klens[i]) begin
         configure(klens[i], emits[i]);
         send_reads(150);
      end
   endtask

   task automatic test_no_idling();
      configure(KlenWidth'($urandom_range(1, 12)), 1'b1);
      idling_on = 1'b0;
      send_reads(200);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_single_base_query();
      test_ingest_skip();
      test_length_change();
      test_random_phases();
      test_no_idling();
      wait_drained();
      repeat (5) @(posedge clock);
      if (pending_windows.size() != 0) begin
         $error("%0d expected windows never arrived", pending_windows.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS canonical_kmer_extractor_top");
      end else begin
         $display("FAIL canonical_kmer_extractor_top");
      end
      $finish;
   end

endmodule
